/* hw/rtl/rmt_pkg.sv */
// Package for the running median tracker.
// Holds the default sizes and the operation codes that drive the sorted cell chains.
// No dependencies.
`timescale 1ns / 1ps

package rmt_pkg;

	// Default number of samples held and default sample width.
	localparam int DEF_CAPACITY    = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	// Operation applied to every cell of a chain at once.
	typedef enum logic [1:0] {
		OP_HOLD,        // keep contents
		OP_INSERT,      // insert the key in sorted position
		OP_PUSH,        // shift everything back and place a value at the front
		OP_POP_INSERT   // drop the front entry and insert the key
	} cell_op_t;

endpackage

/* hw/rtl/rmt_cell.sv */
// One cell of a sorted chain: a single stored value and its update rule.
// Depends on rmt_pkg for the cell operation codes.
`timescale 1ns / 1ps

module rmt_cell import rmt_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int SZ_W        = 10,
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  cell_op_t               op,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [SZ_W-1:0]        size,
	input  logic [VALUE_WIDTH-1:0] prev_val,
	input  logic                   prev_lt,
	input  logic [VALUE_WIDTH-1:0] next_val,
	input  logic                   next_lt,
	output logic [VALUE_WIDTH-1:0] val,
	output logic                   lt,
	output logic [VALUE_WIDTH-1:0] val_nxt
);

	logic [VALUE_WIDTH-1:0] val_q;
	logic                   occ;

	// The cell is occupied when its position lies below the chain size. An occupied
	// cell whose value does not exceed the key sorts in front of the key.
	assign occ = SZ_W'(IDX) < size;
	assign lt  = occ && (val_q <= key);
	assign val = val_q;

	// Next value from this cell, its neighbors and the key.
	always_comb begin
		unique case (op)
			OP_HOLD:       val_nxt = val_q;
			OP_INSERT:     val_nxt = lt ? val_q : (prev_lt ? key : prev_val);
			OP_PUSH:       val_nxt = prev_val;
			OP_POP_INSERT: val_nxt = next_lt ? next_val : (lt ? key : val_q);
			default:       val_nxt = val_q;
		endcase
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule

/* hw/rtl/rmt_chain.sv */
// Row of sorted cells kept in ascending order, front entry at position zero.
// Depends on rmt_pkg and rmt_cell.
`timescale 1ns / 1ps

module rmt_chain import rmt_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int DEPTH       = (DEF_CAPACITY + 1) / 2,
	localparam int SZ_W       = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  cell_op_t               op,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [SZ_W-1:0]        size,
	input  logic [VALUE_WIDTH-1:0] push_val,
	output logic [VALUE_WIDTH-1:0] front_val,
	output logic [VALUE_WIDTH-1:0] front_nxt
);

	logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
	logic [VALUE_WIDTH-1:0] cell_nxt [DEPTH];
	logic                   cell_lt  [DEPTH];

	// Each cell talks only to its two neighbors. The front cell sees the pushed
	// value as its predecessor, and the last cell sees an empty successor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] pv;
		logic                   pl;
		logic [VALUE_WIDTH-1:0] nv;
		logic                   nl;

		if (i == 0) begin : g_first
			assign pv = push_val;
			assign pl = 1'b1;
		end else begin : g_mid_prev
			assign pv = cell_val[i-1];
			assign pl = cell_lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign nv = cell_val[i];
			assign nl = 1'b0;
		end else begin : g_mid_next
			assign nv = cell_val[i+1];
			assign nl = cell_lt[i+1];
		end

		rmt_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.SZ_W        (SZ_W),
			.IDX         (i)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.key      (key),
			.size     (size),
			.prev_val (pv),
			.prev_lt  (pl),
			.next_val (nv),
			.next_lt  (nl),
			.val      (cell_val[i]),
			.lt       (cell_lt[i]),
			.val_nxt  (cell_nxt[i])
		);
	end

	assign front_val = cell_val[0];
	assign front_nxt = cell_nxt[0];

endmodule

/* hw/rtl/running_median_tracker.sv */
// Running median tracker, top level.
// Depends on rmt_pkg and rmt_chain.
//
// Usage: each input transaction (in_valid/in_ready) carries one signed sample.
// Every input transaction produces exactly one output transaction
// (out_valid/out_ready) with the lower median of all samples held so far, the
// number of samples held, and full_res, which is set when the sample was dropped
// because CAPACITY samples are already held.
// out_valid is registered and rises in the cycle after acceptance. One transaction
// per cycle is sustained while out_ready stays high, since both cell chains update
// together and every cell compares against the new sample at once.
// The samples sit in two rows of (CAPACITY+1)/2 cells: the lower half stored
// inverted so its largest member sits at the front, and the upper half with its
// smallest member at the front. A new sample is inserted, with one front entry
// moving across the halves when needed, in the same cycle.
// Reset clears the sample count and the output valid; cell contents are not reset
// and are never read before being written. When the receiver stalls, the result
// is held and in_ready stays low until it is taken.
`timescale 1ns / 1ps

module running_median_tracker import rmt_pkg::*; #(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] median,
	output logic [CNT_W-1:0]       sample_count,
	output logic                   full_res
);

	localparam int HALF = (CAPACITY + 1) / 2;
	localparam int SZ_W = $clog2(HALF + 1);
	localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] median_q;
	logic                   full_q;

	logic                   in_fire;
	logic                   full;
	logic [SZ_W-1:0]        lo_sz;
	logic [SZ_W-1:0]        up_sz;
	logic [VALUE_WIDTH-1:0] key_b;
	logic [VALUE_WIDTH-1:0] lo_front;
	logic [VALUE_WIDTH-1:0] lo_front_nxt;
	logic [VALUE_WIDTH-1:0] up_front;
	logic [VALUE_WIDTH-1:0] up_front_nxt;
	logic [VALUE_WIDTH-1:0] lo_max_b;
	cell_op_t               lo_op;
	cell_op_t               up_op;
	logic [CNT_W-1:0]       cnt_nxt;

	// Handshake: a new transaction is taken once the output register is free or is being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Biased keys compare as unsigned in signed order; the lower half is inverted.
	assign key_b    = sample ^ SIGN_BIT;
	assign full     = cnt_q >= CNT_W'(CAPACITY);
	assign lo_sz    = SZ_W'(({1'b0, cnt_q} + 1'b1) >> 1);
	assign up_sz    = SZ_W'(cnt_q >> 1);
	assign lo_max_b = ~lo_front;

	// Decide what each half does with the new sample.
	always_comb begin
		lo_op   = OP_HOLD;
		up_op   = OP_HOLD;
		cnt_nxt = cnt_q;
		if (in_fire && !full) begin
			cnt_nxt = cnt_q + 1'b1;
			if (!cnt_q[0]) begin
				// Halves equal: the lower half grows.
				if (up_sz == '0 || key_b <= up_front) begin
					lo_op = OP_INSERT;
				end else begin
					lo_op = OP_PUSH;
					up_op = OP_POP_INSERT;
				end
			end else begin
				// Lower half is larger: the upper half grows.
				if (key_b >= lo_max_b) begin
					up_op = OP_INSERT;
				end else begin
					up_op = OP_PUSH;
					lo_op = OP_POP_INSERT;
				end
			end
		end
	end

	rmt_chain #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DEPTH       (HALF)
	) u_lower (
		.clk       (clk),
		.op        (lo_op),
		.key       (~key_b),
		.size      (lo_sz),
		.push_val  (~up_front),
		.front_val (lo_front),
		.front_nxt (lo_front_nxt)
	);

	rmt_chain #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DEPTH       (HALF)
	) u_upper (
		.clk       (clk),
		.op        (up_op),
		.key       (key_b),
		.size      (up_sz),
		.push_val  (lo_max_b),
		.front_val (up_front),
		.front_nxt (up_front_nxt)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, taken from the new front of the lower half.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			median_q <= (~lo_front_nxt) ^ SIGN_BIT;
			full_q   <= full;
		end
	end

	assign out_valid    = out_valid_q;
	assign median       = median_q;
	assign sample_count = cnt_q;
	assign full_res     = full_q;

	// The count never runs past the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("sample count exceeds capacity");

	// A sample that is kept raises the count by exactly one.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !full |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("sample count did not advance");

	// A dropped sample is only reported when storage is full.
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && full_q |-> cnt_q == CNT_W'(CAPACITY))
		else $error("full flag without full storage");

	// Every accepted transaction leaves a result waiting.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted transaction produced no result");

	// After an update with both halves non-empty, the lower maximum stays at or
	// below the upper minimum.
	a_halves_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !full && cnt_q != '0 |-> (~lo_front_nxt) <= up_front_nxt)
		else $error("lower half rises above upper half");

endmodule
